/* rtl/vpf_pkg.sv */
// Shared types, command codes and saturation helper for the vector path flattener.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package vpf_pkg;

	localparam int PW = 24;
	localparam int EW = 28;
	localparam int CURVE_STEPS_DEF = 11;
	localparam int QDEPTH = 2;

	localparam logic [3:0] CMD_MOVE   = 4'd0;
	localparam logic [3:0] CMD_LINE   = 4'd1;
	localparam logic [3:0] CMD_HORIZ  = 4'd2;
	localparam logic [3:0] CMD_VERT   = 4'd3;
	localparam logic [3:0] CMD_CUBIC  = 4'd4;
	localparam logic [3:0] CMD_SCUBIC = 4'd5;
	localparam logic [3:0] CMD_QUAD   = 4'd6;
	localparam logic [3:0] CMD_SQUAD  = 4'd7;
	localparam logic [3:0] CMD_CLOSE  = 4'd8;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_CUBIC = 2'd1;
	localparam logic [1:0] KIND_QUAD  = 2'd2;

	typedef logic signed [PW-1:0] coord_t;
	typedef logic signed [EW-1:0] wide_t;

	typedef struct packed {
		logic [3:0] cmd;
		logic       is_relative;
		coord_t     a_x;
		coord_t     a_y;
		coord_t     b_x;
		coord_t     b_y;
		coord_t     e_x;
		coord_t     e_y;
	} entry_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic starts;
		logic closes;
	} tag_t;

	localparam wide_t COORD_MAX = EW'(8388607);
	localparam wide_t COORD_MIN = -EW'(8388608);

	function automatic coord_t sat_coord(input wide_t v);
		coord_t r;
		if (v > COORD_MAX) begin
			r = COORD_MAX[PW-1:0];
		end else if (v < COORD_MIN) begin
			r = COORD_MIN[PW-1:0];
		end else begin
			r = v[PW-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/vpf_front.sv */
// Input stage: takes command beats, drops unknown command codes, holds one entry.
// Depends on vpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vpf_front import vpf_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_stall,
	input  wire logic [3:0] cmd,
	input  wire logic   is_relative,
	input  wire coord_t ctrl_a_x,
	input  wire coord_t ctrl_a_y,
	input  wire coord_t ctrl_b_x,
	input  wire coord_t ctrl_b_y,
	input  wire coord_t end_x,
	input  wire coord_t end_y,
	output logic        push,
	output entry_t      push_data,
	input  wire logic   q_full
);

	logic   hold_valid_q;
	entry_t hold_q;
	logic   accept;
	logic   legal;

	assign in_stall  = hold_valid_q && q_full;
	assign accept    = in_valid && !in_stall;
	assign legal     = (cmd <= CMD_CLOSE);
	assign push      = hold_valid_q && !q_full;
	assign push_data = hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (accept && legal) begin
			hold_valid_q <= 1'b1;
		end else if (push) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && legal) begin
			hold_q <= '{cmd: cmd, is_relative: is_relative, a_x: ctrl_a_x, a_y: ctrl_a_y,
				b_x: ctrl_b_x, b_y: ctrl_b_y, e_x: end_x, e_y: end_y};
		end
	end

endmodule

`default_nettype wire

/* rtl/vpf_queue.sv */
// Two-entry command queue between the input stage and the path sequencer.
// Depends on vpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vpf_queue import vpf_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_data,
	output logic        full,
	input  wire logic   pop,
	output entry_t      pop_data,
	output logic        empty
);

	localparam int PTRW = $clog2(QDEPTH);
	localparam int CNTW = $clog2(QDEPTH + 1);

	entry_t            mem_q [QDEPTH];
	logic [PTRW-1:0]   wp_q;
	logic [PTRW-1:0]   rp_q;
	logic [CNTW-1:0]   cnt_q;

	assign full     = (cnt_q == CNTW'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PTRW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PTRW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

/* rtl/vpf_back.sv */
// Path sequencer: keeps the current and control points, resolves relative and smooth
// commands, elevates quadratics and issues sample indexes. Depends on vpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vpf_back import vpf_pkg::*; #(
	parameter int CURVE_STEPS = CURVE_STEPS_DEF,
	localparam int IW = $clog2(CURVE_STEPS + 1)
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   q_empty,
	input  wire entry_t q_data,
	output logic        q_pop,
	input  wire logic   pipe_busy,
	input  wire logic   pipe_en,
	output tag_t        issue,
	output logic [IW-1:0] issue_idx,
	output coord_t      p_x [4],
	output coord_t      p_y [4]
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ELEV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	localparam logic [IW-1:0] LAST_IDX = IW'(CURVE_STEPS);
	localparam logic [27:0]   DIV3_M   = 28'd178956971;
	localparam wide_t         DIV_OFS  = EW'(3 * 2**25);
	localparam wide_t         DIV_BIAS = EW'(2**25);

	logic [1:0]    state_q;
	logic [IW-1:0] i_q;
	logic [1:0]    ej_q;
	coord_t        cur_x_q, cur_y_q, ctrl_x_q, ctrl_y_q;
	logic [1:0]    kind_q;
	logic          starts_q, closes_q;
	coord_t        px_q [4];
	coord_t        py_q [4];
	coord_t        qx_q, qy_q;

	coord_t base_x, base_y;
	coord_t abs_ax, abs_ay, abs_bx, abs_by, abs_ex, abs_ey;
	coord_t refl_x, refl_y;
	coord_t pt_x, pt_y;
	coord_t s1_x, s1_y;
	coord_t qsel_x, qsel_y;
	coord_t el_p, el_q, el_res;
	wide_t  el_x;
	logic [26:0] el_y;
	logic [54:0] el_prod;
	wide_t  el_fl;

	assign q_pop = (state_q == ST_IDLE) && !q_empty && !pipe_busy;

	always_comb begin
		base_x = q_data.is_relative ? cur_x_q : '0;
		base_y = q_data.is_relative ? cur_y_q : '0;
		abs_ax = sat_coord(EW'(q_data.a_x) + EW'(base_x));
		abs_ay = sat_coord(EW'(q_data.a_y) + EW'(base_y));
		abs_bx = sat_coord(EW'(q_data.b_x) + EW'(base_x));
		abs_by = sat_coord(EW'(q_data.b_y) + EW'(base_y));
		abs_ex = sat_coord(EW'(q_data.e_x) + EW'(base_x));
		abs_ey = sat_coord(EW'(q_data.e_y) + EW'(base_y));
		refl_x = sat_coord(EW'(cur_x_q) + EW'(cur_x_q) - EW'(ctrl_x_q));
		refl_y = sat_coord(EW'(cur_y_q) + EW'(cur_y_q) - EW'(ctrl_y_q));

		pt_x = cur_x_q;
		pt_y = cur_y_q;
		case (q_data.cmd)
			CMD_MOVE, CMD_LINE: begin
				pt_x = abs_ex;
				pt_y = abs_ey;
			end
			CMD_HORIZ: pt_x = abs_ex;
			CMD_VERT:  pt_y = abs_ey;
			default: ;
		endcase

		s1_x = (kind_q == KIND_CUBIC) ? refl_x : cur_x_q;
		s1_y = (kind_q == KIND_CUBIC) ? refl_y : cur_y_q;

		if (q_data.cmd == CMD_QUAD) begin
			qsel_x = abs_ax;
			qsel_y = abs_ay;
		end else if (kind_q == KIND_QUAD) begin
			qsel_x = refl_x;
			qsel_y = refl_y;
		end else begin
			qsel_x = cur_x_q;
			qsel_y = cur_y_q;
		end
	end

	// Elevated control: p + floor((2(q - p) + 1) / 3), the division done by reciprocal
	// multiply on an offset that keeps the dividend positive.
	always_comb begin
		if (ej_q[1]) begin
			el_p = ej_q[0] ? py_q[3] : px_q[3];
		end else begin
			el_p = ej_q[0] ? py_q[0] : px_q[0];
		end
		el_q    = ej_q[0] ? qy_q : qx_q;
		el_x    = (EW'(el_q) - EW'(el_p)) + (EW'(el_q) - EW'(el_p)) + EW'(1);
		el_y    = 27'(el_x + DIV_OFS);
		el_prod = 55'(el_y) * 55'(DIV3_M);
		el_fl   = EW'(el_prod[54:29]) - DIV_BIAS;
		el_res  = sat_coord(EW'(el_p) + el_fl);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			i_q      <= '0;
			ej_q     <= '0;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			ctrl_x_q <= '0;
			ctrl_y_q <= '0;
			kind_q   <= KIND_NONE;
			starts_q <= 1'b0;
			closes_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						case (q_data.cmd)
							CMD_MOVE, CMD_LINE, CMD_HORIZ, CMD_VERT, CMD_CLOSE: begin
								cur_x_q  <= pt_x;
								cur_y_q  <= pt_y;
								ctrl_x_q <= pt_x;
								ctrl_y_q <= pt_y;
								kind_q   <= KIND_NONE;
								i_q      <= LAST_IDX;
								starts_q <= (q_data.cmd == CMD_MOVE);
								closes_q <= (q_data.cmd == CMD_CLOSE);
								state_q  <= ST_EMIT;
							end
							CMD_CUBIC, CMD_SCUBIC: begin
								cur_x_q  <= abs_ex;
								cur_y_q  <= abs_ey;
								ctrl_x_q <= (q_data.cmd == CMD_CUBIC) ? abs_bx : abs_ax;
								ctrl_y_q <= (q_data.cmd == CMD_CUBIC) ? abs_by : abs_ay;
								kind_q   <= KIND_CUBIC;
								i_q      <= IW'(1);
								starts_q <= 1'b0;
								closes_q <= 1'b0;
								state_q  <= ST_EMIT;
							end
							CMD_QUAD, CMD_SQUAD: begin
								cur_x_q  <= abs_ex;
								cur_y_q  <= abs_ey;
								ctrl_x_q <= qsel_x;
								ctrl_y_q <= qsel_y;
								kind_q   <= KIND_QUAD;
								i_q      <= IW'(1);
								ej_q     <= '0;
								starts_q <= 1'b0;
								closes_q <= 1'b0;
								state_q  <= ST_ELEV;
							end
							default: ;
						endcase
					end
				end
				ST_ELEV: begin
					ej_q <= ej_q + 1'b1;
					if (ej_q == 2'd3) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (pipe_en) begin
						if (i_q == LAST_IDX) begin
							state_q <= ST_IDLE;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_pop) begin
			case (q_data.cmd)
				CMD_CUBIC: begin
					px_q[0] <= cur_x_q; py_q[0] <= cur_y_q;
					px_q[1] <= abs_ax;  py_q[1] <= abs_ay;
					px_q[2] <= abs_bx;  py_q[2] <= abs_by;
					px_q[3] <= abs_ex;  py_q[3] <= abs_ey;
				end
				CMD_SCUBIC: begin
					px_q[0] <= cur_x_q; py_q[0] <= cur_y_q;
					px_q[1] <= s1_x;    py_q[1] <= s1_y;
					px_q[2] <= abs_ax;  py_q[2] <= abs_ay;
					px_q[3] <= abs_ex;  py_q[3] <= abs_ey;
				end
				CMD_QUAD, CMD_SQUAD: begin
					px_q[0] <= cur_x_q; py_q[0] <= cur_y_q;
					px_q[3] <= abs_ex;  py_q[3] <= abs_ey;
					qx_q    <= qsel_x;  qy_q    <= qsel_y;
				end
				default: begin
					for (int k = 0; k < 4; k++) begin
						px_q[k] <= pt_x;
						py_q[k] <= pt_y;
					end
				end
			endcase
		end else if (state_q == ST_ELEV) begin
			case (ej_q)
				2'd0:    px_q[1] <= el_res;
				2'd1:    py_q[1] <= el_res;
				2'd2:    px_q[2] <= el_res;
				default: py_q[2] <= el_res;
			endcase
		end
	end

	assign issue.valid  = (state_q == ST_EMIT);
	assign issue.last   = (i_q == LAST_IDX);
	assign issue.starts = starts_q;
	assign issue.closes = closes_q;
	assign issue_idx    = i_q;
	assign p_x          = px_q;
	assign p_y          = py_q;

	a_elev_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ELEV && ej_q == 2'd3) |=> (state_q == ST_EMIT))
		else $error("elevation did not hand over to sample issue");

	a_flag_single: assert property (@(posedge clk) disable iff (!arst_n)
		(issue.valid && (issue.starts || issue.closes)) |-> issue.last)
		else $error("move or close issued more than one point");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_busy |=> ($stable(cur_x_q) && $stable(cur_y_q) && $stable(kind_q)))
		else $error("path state changed while samples were in flight");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid |-> (i_q != '0 && i_q <= LAST_IDX))
		else $error("sample index out of range");

endmodule

`default_nettype wire

/* rtl/vpf_sampler.sv */
// Sample pipeline: four multiply-accumulate stages over the Bernstein coefficient table,
// then rounding, saturation and the output register. Depends on vpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vpf_sampler import vpf_pkg::*; #(
	parameter int CURVE_STEPS = CURVE_STEPS_DEF,
	localparam int IW = $clog2(CURVE_STEPS + 1)
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire tag_t   issue,
	input  wire logic [IW-1:0] issue_idx,
	input  wire coord_t p_x [4],
	input  wire coord_t p_y [4],
	output logic        pipe_busy,
	output logic        pipe_en,
	output logic        out_valid,
	input  wire logic   out_stall,
	output coord_t      out_x,
	output coord_t      out_y,
	output logic        starts_path,
	output logic        closes_path,
	output logic        last_of_run
);

	localparam int  CW  = 17;
	localparam int  AW  = 44;
	localparam longint N3L = longint'(CURVE_STEPS) * longint'(CURVE_STEPS) * longint'(CURVE_STEPS);

	logic [CW-1:0] coef_tbl [4][CURVE_STEPS+1];

	for (genvar g = 0; g <= CURVE_STEPS; g++) begin : g_coef
		localparam longint ML = longint'(CURVE_STEPS - g);
		localparam longint GL = longint'(g);
		localparam longint C0 = (ML * ML * ML * 65536 + N3L / 2) / N3L;
		localparam longint C1 = (3 * ML * ML * GL * 65536 + N3L / 2) / N3L;
		localparam longint C2 = (3 * ML * GL * GL * 65536 + N3L / 2) / N3L;
		localparam longint C3 = (GL * GL * GL * 65536 + N3L / 2) / N3L;
		assign coef_tbl[0][g] = CW'(C0);
		assign coef_tbl[1][g] = CW'(C1);
		assign coef_tbl[2][g] = CW'(C2);
		assign coef_tbl[3][g] = CW'(C3);
	end

	function automatic logic signed [AW-1:0] mac(input logic signed [AW-1:0] acc,
		input logic [CW-1:0] c, input coord_t p);
		logic signed [CW:0] cs;
		cs = {1'b0, c};
		return acc + AW'(cs) * AW'(p);
	endfunction

	tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic [IW-1:0] idx_s1, idx_s2, idx_s3;
	logic signed [AW-1:0] accx_s1, accx_s2, accx_s3, accx_s4;
	logic signed [AW-1:0] accy_s1, accy_s2, accy_s3, accy_s4;
	logic signed [AW-1:0] rnd_x, rnd_y;

	logic   out_valid_q;
	coord_t out_x_q, out_y_q;
	logic   starts_q, closes_q, last_q;

	assign pipe_en   = !out_valid_q || !out_stall;
	assign pipe_busy = tag_s1.valid || tag_s2.valid || tag_s3.valid || tag_s4.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1      <= '0;
			tag_s2      <= '0;
			tag_s3      <= '0;
			tag_s4      <= '0;
			out_valid_q <= 1'b0;
		end else if (pipe_en) begin
			tag_s1      <= issue;
			tag_s2      <= tag_s1;
			tag_s3      <= tag_s2;
			tag_s4      <= tag_s3;
			out_valid_q <= tag_s4.valid;
		end
	end

	assign rnd_x = accx_s4 + AW'(32768);
	assign rnd_y = accy_s4 + AW'(32768);

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			idx_s1  <= issue_idx;
			accx_s1 <= mac('0, coef_tbl[0][issue_idx], p_x[0]);
			accy_s1 <= mac('0, coef_tbl[0][issue_idx], p_y[0]);
			idx_s2  <= idx_s1;
			accx_s2 <= mac(accx_s1, coef_tbl[1][idx_s1], p_x[1]);
			accy_s2 <= mac(accy_s1, coef_tbl[1][idx_s1], p_y[1]);
			idx_s3  <= idx_s2;
			accx_s3 <= mac(accx_s2, coef_tbl[2][idx_s2], p_x[2]);
			accy_s3 <= mac(accy_s2, coef_tbl[2][idx_s2], p_y[2]);
			accx_s4 <= mac(accx_s3, coef_tbl[3][idx_s3], p_x[3]);
			accy_s4 <= mac(accy_s3, coef_tbl[3][idx_s3], p_y[3]);
			out_x_q  <= sat_coord(rnd_x[AW-1:16]);
			out_y_q  <= sat_coord(rnd_y[AW-1:16]);
			starts_q <= tag_s4.starts;
			closes_q <= tag_s4.closes;
			last_q   <= tag_s4.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign starts_path = starts_q;
	assign closes_path = closes_q;
	assign last_of_run = last_q;

endmodule

`default_nettype wire

/* rtl/vector_path_flattener_core.sv */
// Vector path flattener: turns parsed path commands into a stream of flattened points.
// Depends on vpf_pkg, vpf_front, vpf_queue, vpf_back and vpf_sampler.
//
// Input channel (in_valid / in_stall): one beat is one path command, absolute or
// relative, coordinates in signed Q15.8. Unknown command codes are taken and dropped.
// Output channel (out_valid / out_stall): one beat is one point. Move, line,
// horizontal, vertical and close give one point each; curves give CURVE_STEPS points,
// the last one flagged with last_of_run.
// How long a command occupies the sequencer is set by the four-stage sample pipeline,
// which shares the held control points and drains before the next command loads them,
// and by the single divide-by-three multiplier that elevates the four quadratic control
// coordinates one per cycle.
// Reset clears the current point, the stored control point and the queue.
// While out_stall and out_valid are both high the sample pipeline and the output beat
// hold; commands keep entering until the two-entry queue and the input register are full.
`timescale 1ns / 1ps
`default_nettype none

module vector_path_flattener_core import vpf_pkg::*; #(
	parameter int CURVE_STEPS = CURVE_STEPS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_stall,
	input  wire logic [3:0] cmd,
	input  wire logic   is_relative,
	input  wire coord_t ctrl_a_x,
	input  wire coord_t ctrl_a_y,
	input  wire coord_t ctrl_b_x,
	input  wire coord_t ctrl_b_y,
	input  wire coord_t end_x,
	input  wire coord_t end_y,
	output logic        out_valid,
	input  wire logic   out_stall,
	output coord_t      out_x,
	output coord_t      out_y,
	output logic        starts_path,
	output logic        closes_path,
	output logic        last_of_run
);

	localparam int IW = $clog2(CURVE_STEPS + 1);

	logic          push, q_full, q_pop, q_empty;
	entry_t        push_data, q_data;
	logic          pipe_busy, pipe_en;
	tag_t          issue;
	logic [IW-1:0] issue_idx;
	coord_t        p_x [4];
	coord_t        p_y [4];

	vpf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.is_relative(is_relative),
		.ctrl_a_x   (ctrl_a_x),
		.ctrl_a_y   (ctrl_a_y),
		.ctrl_b_x   (ctrl_b_x),
		.ctrl_b_y   (ctrl_b_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.push       (push),
		.push_data  (push_data),
		.q_full     (q_full)
	);

	vpf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_data),
		.empty    (q_empty)
	);

	vpf_back #(.CURVE_STEPS(CURVE_STEPS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_data),
		.q_pop    (q_pop),
		.pipe_busy(pipe_busy),
		.pipe_en  (pipe_en),
		.issue    (issue),
		.issue_idx(issue_idx),
		.p_x      (p_x),
		.p_y      (p_y)
	);

	vpf_sampler #(.CURVE_STEPS(CURVE_STEPS)) u_sampler (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue      (issue),
		.issue_idx  (issue_idx),
		.p_x        (p_x),
		.p_y        (p_y),
		.pipe_busy  (pipe_busy),
		.pipe_en    (pipe_en),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_x      (out_x),
		.out_y      (out_y),
		.starts_path(starts_path),
		.closes_path(closes_path),
		.last_of_run(last_of_run)
	);

endmodule

`default_nettype wire

/* bench/vector_path_flattener_core_tb.sv */
// Self-checking testbench for vector_path_flattener_core: it drives path commands and checks
// every flattened point against its own fixed-point flattener, with random idling on both sides.
// Depends on vpf_pkg and the RTL of the block.
`timescale 1ns / 1ps

module vector_path_flattener_core_tb;
	import vpf_pkg::*;

	localparam int PERIOD = 10;
	localparam int RANDOM_COMMANDS = 280;
	localparam int STEPS = CURVE_STEPS_DEF;
	localparam coord_t C_MAX = 24'sh7FFFFF;
	localparam coord_t C_MIN = 24'sh800000;
	localparam logic [3:0] CMD_UNUSED_LO = CMD_CLOSE + 4'd1;
	localparam logic [3:0] CMD_UNUSED_HI = 4'hF;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   starts;
		logic   closes;
		logic   last;
	} point_t;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	class flat_point_board;
		point_t  due_points[$];
		int      bad;
		longint  pen_x, pen_y, handle_x, handle_y;
		logic [1:0] last_kind;
		longint  weight[4][STEPS + 1];
		longint  bez_x[4], bez_y[4];

		function new();
			longint n3, m;
			bad = 0;
			pen_x = 0;
			pen_y = 0;
			handle_x = 0;
			handle_y = 0;
			last_kind = KIND_NONE;
			n3 = longint'(STEPS) * STEPS * STEPS;
			for (int i = 1; i <= STEPS; i++) begin
				m = STEPS - i;
				weight[0][i] = (m * m * m * 65536 + n3 / 2) / n3;
				weight[1][i] = (3 * m * m * i * 65536 + n3 / 2) / n3;
				weight[2][i] = (3 * m * i * i * 65536 + n3 / 2) / n3;
				weight[3][i] = (longint'(i) * i * i * 65536 + n3 / 2) / n3;
			end
		endfunction

		function longint sat(longint v);
			if (v > 8388607) return 8388607;
			if (v < -8388608) return -8388608;
			return v;
		endfunction

		function longint fdiv(longint s, longint d);
			longint q;
			q = s / d;
			if ((s % d) < 0) q--;
			return q;
		endfunction

		function longint lift(longint p, longint q);
			return sat(p + fdiv(2 * (q - p) + 1, 3));
		endfunction

		function void push(longint x, longint y, bit s, bit c, bit l);
			point_t p;
			p.x = x[PW-1:0];
			p.y = y[PW-1:0];
			p.starts = s;
			p.closes = c;
			p.last = l;
			due_points = {due_points, p};
		endfunction

		function void emit_curve();
			longint sx, sy;
			for (int i = 1; i <= STEPS; i++) begin
				sx = 0;
				sy = 0;
				for (int k = 0; k < 4; k++) begin
					sx += weight[k][i] * bez_x[k];
					sy += weight[k][i] * bez_y[k];
				end
				push(sat(fdiv(sx + 32768, 65536)), sat(fdiv(sy + 32768, 65536)),
					1'b0, 1'b0, i == STEPS);
			end
			pen_x = bez_x[3];
			pen_y = bez_y[3];
		endfunction

		function void take_command(entry_t e);
			longint ox, oy, ax, ay, cx, cy, ex, ey, qx, qy;
			ox = e.is_relative ? pen_x : 0;
			oy = e.is_relative ? pen_y : 0;
			ax = sat($signed(e.a_x) + ox);
			ay = sat($signed(e.a_y) + oy);
			cx = sat($signed(e.b_x) + ox);
			cy = sat($signed(e.b_y) + oy);
			ex = sat($signed(e.e_x) + ox);
			ey = sat($signed(e.e_y) + oy);
			case (e.cmd)
				CMD_MOVE, CMD_LINE, CMD_HORIZ, CMD_VERT, CMD_CLOSE: begin
					if (e.cmd != CMD_VERT && e.cmd != CMD_CLOSE) pen_x = ex;
					if (e.cmd != CMD_HORIZ && e.cmd != CMD_CLOSE) pen_y = ey;
					push(pen_x, pen_y, e.cmd == CMD_MOVE, e.cmd == CMD_CLOSE, 1'b1);
					handle_x = pen_x;
					handle_y = pen_y;
					last_kind = KIND_NONE;
				end
				CMD_CUBIC, CMD_SCUBIC: begin
					bez_x[0] = pen_x;
					bez_y[0] = pen_y;
					if (e.cmd == CMD_CUBIC) begin
						bez_x[1] = ax;
						bez_y[1] = ay;
						bez_x[2] = cx;
						bez_y[2] = cy;
					end else begin
						if (last_kind == KIND_CUBIC) begin
							bez_x[1] = sat(2 * pen_x - handle_x);
							bez_y[1] = sat(2 * pen_y - handle_y);
						end else begin
							bez_x[1] = pen_x;
							bez_y[1] = pen_y;
						end
						bez_x[2] = ax;
						bez_y[2] = ay;
					end
					bez_x[3] = ex;
					bez_y[3] = ey;
					emit_curve();
					handle_x = bez_x[2];
					handle_y = bez_y[2];
					last_kind = KIND_CUBIC;
				end
				CMD_QUAD, CMD_SQUAD: begin
					if (e.cmd == CMD_QUAD) begin
						qx = ax;
						qy = ay;
					end else if (last_kind == KIND_QUAD) begin
						qx = sat(2 * pen_x - handle_x);
						qy = sat(2 * pen_y - handle_y);
					end else begin
						qx = pen_x;
						qy = pen_y;
					end
					bez_x[0] = pen_x;
					bez_y[0] = pen_y;
					bez_x[1] = lift(pen_x, qx);
					bez_y[1] = lift(pen_y, qy);
					bez_x[2] = lift(ex, qx);
					bez_y[2] = lift(ey, qy);
					bez_x[3] = ex;
					bez_y[3] = ey;
					emit_curve();
					handle_x = qx;
					handle_y = qy;
					last_kind = KIND_QUAD;
				end
				default: begin
				end
			endcase
		endfunction

		function void check_point(point_t got);
			point_t want;
			if (due_points.size() == 0) begin
				bad++;
				if (bad <= 10) begin
					$display("%0t: unexpected point x=%h y=%h s=%b c=%b l=%b", $realtime,
						got.x, got.y, got.starts, got.closes, got.last);
				end
				return;
			end
			want = due_points.pop_front();
			if (got !== want) begin
				bad++;
				if (bad <= 10) begin
					$display("%0t: point mismatch, want x=%h y=%h s=%b c=%b l=%b", $realtime,
						want.x, want.y, want.starts, want.closes, want.last);
					$display("%0t:                   got x=%h y=%h s=%b c=%b l=%b", $realtime,
						got.x, got.y, got.starts, got.closes, got.last);
				end
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [3:0] cmd = '0;
	logic       is_relative = 1'b0;
	coord_t     ctrl_a_x = '0;
	coord_t     ctrl_a_y = '0;
	coord_t     ctrl_b_x = '0;
	coord_t     ctrl_b_y = '0;
	coord_t     end_x = '0;
	coord_t     end_y = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	coord_t     out_x;
	coord_t     out_y;
	logic       starts_path;
	logic       closes_path;
	logic       last_of_run;

	flat_point_board sb;
	int          burst_left = 0;
	int          commands_sent = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;
	int          stall_phase = 0;
	logic [3:0]  draw_codes[7] = '{CMD_LINE, CMD_HORIZ, CMD_VERT, CMD_CUBIC, CMD_SCUBIC,
		CMD_QUAD, CMD_SQUAD};

	vector_path_flattener_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.is_relative (is_relative),
		.ctrl_a_x    (ctrl_a_x),
		.ctrl_a_y    (ctrl_a_y),
		.ctrl_b_x    (ctrl_b_x),
		.ctrl_b_y    (ctrl_b_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_x       (out_x),
		.out_y       (out_y),
		.starts_path (starts_path),
		.closes_path (closes_path),
		.last_of_run (last_of_run)
	);

	always #(PERIOD / 2) clk = ~clk;

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 300);
		end
		stall_left--;
		stall_phase++;
		case (stall_mode)
			STALL_NONE:  out_stall = 1'b0;
			STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
			default:     out_stall = ((stall_phase % 9) < 4);
		endcase
	end

	always @(posedge clk) begin
		point_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.x = out_x;
			got.y = out_y;
			got.starts = starts_path;
			got.closes = closes_path;
			got.last = last_of_run;
			sb.check_point(got);
		end
	end

	task automatic send(entry_t e);
		@(negedge clk);
		if (burst_left == 0) begin
			if ($urandom_range(0, 4) == 0) begin
				burst_left = $urandom_range(60, 150);
			end else begin
				in_valid = 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				burst_left = $urandom_range(1, 25);
			end
		end
		burst_left--;
		cmd = e.cmd;
		is_relative = e.is_relative;
		ctrl_a_x = e.a_x;
		ctrl_a_y = e.a_y;
		ctrl_b_x = e.b_x;
		ctrl_b_y = e.b_y;
		end_x = e.e_x;
		end_y = e.e_y;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		sb.take_command(e);
		if (e.cmd <= CMD_CLOSE) commands_sent++;
	endtask

	task automatic send_fields(logic [3:0] c, logic rel, coord_t ax, coord_t ay,
		coord_t bx, coord_t by, coord_t ex, coord_t ey);
		entry_t e;
		e.cmd = c;
		e.is_relative = rel;
		e.a_x = ax;
		e.a_y = ay;
		e.b_x = bx;
		e.b_y = by;
		e.e_x = ex;
		e.e_y = ey;
		send(e);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.due_points.size() != 0) @(posedge clk);
	endtask

	function automatic coord_t pick_coord(logic rel);
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			if (rel) return coord_t'($urandom_range(0, 1 << 13) - (1 << 12));
			return coord_t'($urandom_range(0, 1 << 18) - (1 << 17));
		end
		if (r < 80) return coord_t'($urandom());
		if (r < 90) begin
			case ($urandom_range(0, 4))
				0: return C_MAX;
				1: return C_MIN;
				2: return '0;
				3: return '1;
				default: return 24'sd1;
			endcase
		end
		return coord_t'($urandom_range(0, 1 << 22) - (1 << 21));
	endfunction

	function automatic entry_t make_cmd(logic [3:0] c, logic rel);
		entry_t e;
		e.cmd = c;
		e.is_relative = rel;
		e.a_x = pick_coord(rel);
		e.a_y = pick_coord(rel);
		e.b_x = pick_coord(rel);
		e.b_y = pick_coord(rel);
		e.e_x = pick_coord(rel);
		e.e_y = pick_coord(rel);
		return e;
	endfunction

	task automatic random_path();
		int steps;
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 4))
				send(make_cmd(4'($urandom_range(0, int'(CMD_CLOSE))), 1'($urandom())));
			return;
		end
		send(make_cmd(CMD_MOVE, 1'($urandom())));
		steps = $urandom_range(1, 12);
		repeat (steps) begin
			if ($urandom_range(0, 19) == 0)
				send(make_cmd(4'($urandom_range(int'(CMD_UNUSED_LO), int'(CMD_UNUSED_HI))),
					1'($urandom())));
			send(make_cmd(draw_codes[$urandom_range(0, 6)], 1'($urandom())));
		end
		if ($urandom_range(0, 1) == 1) send(make_cmd(CMD_CLOSE, 1'($urandom())));
	endtask

	initial begin
		#5ms;
		$display("vector_path_flattener_core_tb failed");
		$finish;
	end

	initial begin
		int target;
		int paths;
		sb = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_fields(CMD_MOVE, 1'b0, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN);
		send_fields(CMD_LINE, 1'b1, '0, '0, '0, '0, C_MAX, C_MAX);
		send_fields(CMD_HORIZ, 1'b0, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX);
		send_fields(CMD_VERT, 1'b1, '0, '0, '0, '0, '0, 24'sh000100);
		send_fields(CMD_CUBIC, 1'b0, C_MAX, C_MIN, C_MIN, C_MAX, 24'sh001000, -24'sh001000);
		send_fields(CMD_SCUBIC, 1'b0, C_MAX, C_MAX, '0, '0, C_MIN, C_MIN);
		send_fields(CMD_SCUBIC, 1'b1, -24'sh000800, 24'sh000400, '0, '0,
			24'sh002000, 24'sh003000);
		send_fields(CMD_LINE, 1'b0, '0, '0, '0, '0, 24'sh000100, 24'sh000200);
		send_fields(CMD_SCUBIC, 1'b0, 24'sh000300, -24'sh000300, '0, '0,
			24'sh000500, 24'sh000600);
		send_fields(CMD_QUAD, 1'b0, 24'sh004000, -24'sh004000, '0, '0, 24'sh008000, '0);
		send_fields(CMD_SQUAD, 1'b0, '0, '0, '0, '0, 24'sh00C000, 24'sh001000);
		send_fields(CMD_SQUAD, 1'b1, '0, '0, '0, '0, -24'sh002000, 24'sh000800);
		send_fields(CMD_CUBIC, 1'b1, 24'sh000100, 24'sh000100, 24'sh000200, -24'sh000100,
			24'sh000300, '0);
		send_fields(CMD_SQUAD, 1'b0, '0, '0, '0, '0, '0, '0);
		send_fields(CMD_SCUBIC, 1'b0, 24'sh000700, 24'sh000700, '0, '0,
			24'sh000800, 24'sh000900);
		send_fields(CMD_CLOSE, 1'b0, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
		send_fields(CMD_UNUSED_LO, 1'b1, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
		send_fields(CMD_UNUSED_HI, 1'b0, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
		send_fields(CMD_MOVE, 1'b1, '0, '0, '0, '0, 24'sh000010, -24'sh000010);
		send_fields(CMD_QUAD, 1'b1, C_MAX, C_MIN, '0, '0, C_MIN, C_MAX);
		send_fields(CMD_CLOSE, 1'b1, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
		send_fields(CMD_MOVE, 1'b0, '0, '0, '0, '0, '0, '0);
		send_fields(CMD_HORIZ, 1'b1, '0, '0, '0, '0, -24'sh000180, '0);
		send_fields(CMD_VERT, 1'b0, '0, '0, '0, '0, '0, C_MAX);
		send_fields(CMD_SQUAD, 1'b1, '0, '0, '0, '0, C_MAX, C_MIN);
		drain();

		target = commands_sent + RANDOM_COMMANDS;
		paths = 0;
		while (commands_sent < target) begin
			random_path();
			paths++;
			if (paths % 15 == 0) drain();
		end
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.due_points.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		if (sb.bad == 0 && sb.due_points.size() == 0) begin
			$display("vector_path_flattener_core_tb passed");
		end else begin
			$display("vector_path_flattener_core_tb failed");
		end
		$finish;
	end

endmodule
